// ===== design/tkbf_pkg.sv =====
`default_nettype none
package tkbf_pkg;

  // Measurement width; input bits above it are dropped.
  localparam int MEAS_BITS = 16;

  localparam int InW   = 16;
  localparam int MeasW = (MEAS_BITS < InW) ? MEAS_BITS : InW;
  localparam int AccW  = 26;
  localparam int BaseW = 18;
  localparam int CntW  = 16;
  localparam int ThrW  = 8;
  localparam int ShW   = 4;
  localparam int LvlW  = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CntW-1:0] CalibScansRst     = 16'd1000;
  localparam logic [ThrW-1:0] TouchThresholdRst = 8'd200;
  localparam logic [ShW-1:0]  FilterShiftRst    = 4'd4;
  localparam logic [ShW-1:0]  MaxShift          = 4'd8;
  localparam logic [LvlW-1:0] LevelMax          = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CALIB_SCANS     = 2'd0,
    CFG_TOUCH_THRESHOLD = 2'd1,
    CFG_FILTER_SHIFT    = 2'd2
  } tkbf_cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] calib_scans;
    logic [ThrW-1:0] touch_threshold;
    logic [ShW-1:0]  filter_shift;
  } tkbf_cfg_t;

  typedef struct packed {
    logic signed [AccW-1:0]  acc;
    logic signed [BaseW-1:0] baseline;
    logic [CntW-1:0]         scan_count;
    logic                    running;
  } tkbf_state_t;

  typedef struct packed {
    logic                   valid;
    logic signed [AccW-1:0] acc;
    logic [LvlW-1:0]        level;
    logic                   touched;
  } tkbf_result_t;

endpackage
`default_nettype wire

// ===== design/tkbf_update.sv =====
`default_nettype none
module tkbf_update (
  input  tkbf_pkg::tkbf_cfg_t    cfg_i,
  input  tkbf_pkg::tkbf_state_t  state_i,
  input  logic [tkbf_pkg::InW-1:0] meas_i,
  output tkbf_pkg::tkbf_state_t  state_o,
  output tkbf_pkg::tkbf_result_t result_o
);
  import tkbf_pkg::*;

  localparam int SumW = AccW + 2;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [BaseW-1:0] BaseMax = {1'b0, {(BaseW-1){1'b1}}};
  localparam logic signed [BaseW-1:0] BaseMin = {1'b1, {(BaseW-1){1'b0}}};

  logic [ShW-1:0]          shift;
  logic signed [AccW-1:0]  meas_ext;
  logic signed [AccW-1:0]  margin_full;
  logic signed [BaseW-1:0] margin;
  logic signed [AccW-1:0]  acc_decay;
  logic signed [SumW-1:0]  sum;
  logic signed [AccW-1:0]  acc_new;
  logic signed [AccW-1:0]  acc_scaled;
  logic signed [BaseW-1:0] base_new;
  logic [CntW-1:0]         cnt_new;
  logic [CntW-1:0]         target;
  logic [LvlW-1:0]         level;

  always_comb begin
    shift = (cfg_i.filter_shift > MaxShift) ? MaxShift : cfg_i.filter_shift;

    meas_ext = $signed({{(AccW-MeasW){1'b0}}, meas_i[MeasW-1:0]});
    margin_full = meas_ext - AccW'(state_i.baseline);
    if (margin_full > AccW'(BaseMax)) begin
      margin = BaseMax;
    end else if (margin_full < AccW'(BaseMin)) begin
      margin = BaseMin;
    end else begin
      margin = margin_full[BaseW-1:0];
    end

    acc_decay = state_i.acc >>> shift;
    sum = SumW'(state_i.acc) + SumW'(margin) - SumW'(acc_decay);
    if (sum > SumW'(AccMax)) begin
      acc_new = AccMax;
    end else if (sum < SumW'(AccMin)) begin
      acc_new = AccMin;
    end else begin
      acc_new = sum[AccW-1:0];
    end

    acc_scaled = acc_new >>> shift;
    if (acc_scaled > AccW'(BaseMax)) begin
      base_new = BaseMax;
    end else if (acc_scaled < AccW'(BaseMin)) begin
      base_new = BaseMin;
    end else begin
      base_new = acc_scaled[BaseW-1:0];
    end

    if (acc_scaled < 0) begin
      level = '0;
    end else if (acc_scaled > AccW'($signed({1'b0, LevelMax}))) begin
      level = LevelMax;
    end else begin
      level = acc_scaled[LvlW-1:0];
    end

    // zero count behaves as one
    target  = (cfg_i.calib_scans == '0) ? CntW'(1) : cfg_i.calib_scans;
    cnt_new = (state_i.scan_count != '1) ? state_i.scan_count + CntW'(1)
                                         : state_i.scan_count;

    state_o = state_i;
    state_o.acc = acc_new;
    result_o.valid   = state_i.running;
    result_o.acc     = acc_new;
    result_o.level   = level;
    result_o.touched = level > cfg_i.touch_threshold;

    if (!state_i.running) begin
      state_o.scan_count = cnt_new;
      if (cnt_new >= target) begin
        state_o.baseline = base_new;
        state_o.acc      = '0;
        state_o.running  = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/touch_key_baseline_filter_top.sv =====
`default_nettype none
// An accepted transaction passes the input register, then the result register.
// Throughput: one item per cycle while out_ready_i does not hold back a result,
// set by the combinational filter update that feeds the accumulator back.
// Calibration scans give no result. Reset (rst_ni low, asynchronous) clears
// accumulator, baseline, scan count and run flag, and restores the defaults.
module touch_key_baseline_filter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tkbf_pkg::InW-1:0]          discharge_sum_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tkbf_pkg::AccW-1:0]  filter_acc_out_o,
  output logic [tkbf_pkg::LvlW-1:0]         key_level_o,
  output logic                              touched_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tkbf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tkbf_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tkbf_pkg::*;

  tkbf_cfg_t    cfg_q;
  tkbf_state_t  state_q, state_d;
  tkbf_result_t result_d;

  logic            stage_valid_q;
  logic [InW-1:0]  stage_meas_q;
  logic            stage_fire;
  logic            out_valid_q;
  logic signed [AccW-1:0] out_acc_q;
  logic [LvlW-1:0] out_level_q;
  logic            out_touched_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calib_scans     <= CalibScansRst;
      cfg_q.touch_threshold <= TouchThresholdRst;
      cfg_q.filter_shift    <= FilterShiftRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CALIB_SCANS:     cfg_q.calib_scans     <= cfg_data_i[CntW-1:0];
        CFG_TOUCH_THRESHOLD: cfg_q.touch_threshold <= cfg_data_i[ThrW-1:0];
        CFG_FILTER_SHIFT:    cfg_q.filter_shift    <= cfg_data_i[ShW-1:0];
        default: ;
      endcase
    end
  end

  // stage moves on whenever the result register is free this cycle
  assign stage_fire = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || stage_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_meas_q <= discharge_sum_i;
    end
  end

  tkbf_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .meas_i   (stage_meas_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (stage_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_fire) begin
      out_valid_q <= result_d.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire && result_d.valid) begin
      out_acc_q     <= result_d.acc;
      out_level_q   <= result_d.level;
      out_touched_q <= result_d.touched;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filter_acc_out_o = out_acc_q;
  assign key_level_o      = out_level_q;
  assign touched_o        = out_touched_q;

  a_running_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.running |=> state_q.running)
    else $error("run flag dropped");

  a_baseline_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.running |=> $stable(state_q.baseline))
    else $error("baseline changed in run mode");

  a_calib_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_fire && !state_q.running) |=> !out_valid_q)
    else $error("result during calibration");

  a_run_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_fire && state_q.running) |=> out_valid_q)
    else $error("run-mode scan lost its result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid_q |-> in_ready_o)
    else $error("empty input stage not ready");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  import tkbf_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int RstCycles     = 3;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 120;
  localparam int RandItems     = 1600;
  localparam int WatchdogLimit = 2000;

  localparam logic [CfgIdxW-1:0] CfgIdxUnmapped = 2'd3;

  localparam longint AccMax  = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin  = -(longint'(1) <<< (AccW - 1));
  localparam longint BaseMax = (longint'(1) <<< (BaseW - 1)) - 1;
  localparam longint BaseMin = -(longint'(1) <<< (BaseW - 1));
  localparam longint SumMax  = (longint'(1) <<< InW) - 1;

  typedef struct packed {
    logic signed [AccW-1:0] acc;
    logic [LvlW-1:0]        level;
    logic                   touched;
  } key_report_t;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    bit                   typed;
    key_report_t          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   scan_valid = 1'b0;
  logic                   scan_ready;
  logic [InW-1:0]         scan_sum = '0;
  logic                   rep_valid;
  logic                   rep_ready = 1'b0;
  logic signed [AccW-1:0] rep_acc;
  logic [LvlW-1:0]        rep_level;
  logic                   rep_touched;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxW-1:0]     cfg_idx = '0;
  logic [CfgDataW-1:0]    cfg_data = '0;

  // filter model state and register copies
  logic [CntW-1:0]         calib_q;
  logic [ThrW-1:0]         thr_q;
  logic [ShW-1:0]          shift_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [BaseW-1:0] base_q;
  logic [CntW-1:0]         count_q;
  logic                    running_q;

  key_report_t due_reports[$];
  dir_row_t    dir_rows[$];
  int          errors = 0;
  int          quiet = 0;
  bit          hold_req = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  touch_key_baseline_filter_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (scan_valid),
    .in_ready_o       (scan_ready),
    .discharge_sum_i  (scan_sum),
    .out_valid_o      (rep_valid),
    .out_ready_i      (rep_ready),
    .filter_acc_out_o (rep_acc),
    .key_level_o      (rep_level),
    .touched_o        (rep_touched),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // One scan through the baseline filter; returns 1 when it yields a report.
  function automatic bit filter_scan(input logic [InW-1:0] sum, output key_report_t rep);
    int     s;
    int     target;
    longint meas;
    longint margin;
    longint acc_n;
    longint lvl;
    s = (shift_q > MaxShift) ? int'(MaxShift) : int'(shift_q);
    meas = longint'(sum[MeasW-1:0]);
    margin = clip(meas - longint'(base_q), BaseMin, BaseMax);
    acc_n = clip(longint'(acc_q) + margin - (longint'(acc_q) >>> s), AccMin, AccMax);
    rep = '0;
    if (!running_q) begin
      target = (calib_q == '0) ? 1 : int'(calib_q);
      if (count_q != '1) count_q = count_q + 1'b1;
      if (int'(count_q) >= target) begin
        base_q = BaseW'(clip(acc_n >>> s, BaseMin, BaseMax));
        acc_q = '0;
        running_q = 1'b1;
      end else begin
        acc_q = AccW'(acc_n);
      end
      return 1'b0;
    end
    acc_q = AccW'(acc_n);
    lvl = clip(acc_n >>> s, 0, longint'(LevelMax));
    rep.acc = acc_q;
    rep.level = LvlW'(lvl);
    rep.touched = (lvl > longint'(thr_q));
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Levels around the latched baseline, plus far-off, extreme and uniformly random sums.
  function automatic logic [InW-1:0] pick_sum(input int center);
    int     r;
    int     jit;
    longint v;
    r = $urandom_range(0, 99);
    jit = $urandom_range(0, 40);
    if (r < 45) begin
      v = longint'(base_q) + longint'(center + jit - 20);
    end else if (r < 60) begin
      v = longint'(base_q) - longint'($urandom_range(0, 8000));
    end else if (r < 70) begin
      v = (r % 2 == 1) ? SumMax : 0;
    end else begin
      v = longint'($urandom_range(0, 65535));
    end
    return InW'(clip(v, 0, SumMax));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_scan(input logic [InW-1:0] sum, input int gap, input bit typed,
                           input key_report_t want);
    key_report_t rep;
    if (gap > 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    scan_valid <= 1'b1;
    scan_sum <= sum;
    @(posedge clk);
    while (!scan_ready) @(posedge clk);
    if (filter_scan(sum, rep)) due_reports.push_back(typed ? want : rep);
    @(negedge clk);
  endtask

  // Register writes only with the pipe drained; calibration scans leave no report,
  // so the SettleCycles wait covers anything still in flight.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    scan_valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CALIB_SCANS:     calib_q = data[CntW-1:0];
      CFG_TOUCH_THRESHOLD: thr_q = data[ThrW-1:0];
      CFG_FILTER_SHIFT:    shift_q = data[ShW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : report_sink
    int  ready_left;
    int  stall_left;
    bit  hold_done;
    ready_left = 0;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        rep_ready <= 1'b0;
      end else if (ready_left > 0) begin
        ready_left--;
        rep_ready <= 1'b1;
      end else begin
        ready_left = $urandom_range(0, 30);
        stall_left = idle_len();
        rep_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_reports
    key_report_t want;
    if (rst_n && rep_valid && rep_ready) begin
      if (due_reports.size() == 0) begin
        $error("report with none pending: acc %0d level %0d touched %0d",
               rep_acc, rep_level, rep_touched);
        errors++;
      end else begin
        want = due_reports.pop_front();
        if (rep_acc !== want.acc) begin
          $error("filter_acc_out: expected %0d, got %0d", want.acc, rep_acc);
          errors++;
        end
        if (rep_level !== want.level) begin
          $error("key_level: expected %0d, got %0d", want.level, rep_level);
          errors++;
        end
        if (rep_touched !== want.touched) begin
          $error("touched: expected %0d, got %0d", want.touched, rep_touched);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((scan_valid && scan_ready) || (rep_valid && rep_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $error("no transaction for %0d cycles", WatchdogLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          n_items;
    int          phase;
    int          n;
    int          center;
    bit          steady;
    logic [CfgDataW-1:0] data;
    key_report_t none;

    none = '0;
    calib_q = CalibScansRst;
    thr_q = TouchThresholdRst;
    shift_q = FilterShiftRst;
    acc_q = '0;
    base_q = '0;
    count_q = '0;
    running_q = 1'b0;

    // Calibration under reset defaults, then the count drops to zero mid-way:
    // the next scan latches baseline 7440 (shift 4).
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_CALIB_SCANS, 16'd0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd7440, 1'b1,
                                  key_report_t'{26'sd0, 8'd0, 1'b0}});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd10656, 1'b1,
                                  key_report_t'{26'sd3216, 8'd201, 1'b1}});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'hFFFF, 1'b1,
                                  key_report_t'{26'sd61110, 8'd255, 1'b1}});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_TOUCH_THRESHOLD, 16'd255, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_TOUCH_THRESHOLD, 16'hFF00, 1'b0, none});
    // zero shift: accumulator follows the margin directly
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_FILTER_SHIFT, 16'h0000, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd0, 1'b1,
                                  key_report_t'{-26'sd7440, 8'd0, 1'b0}});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd7441, 1'b1,
                                  key_report_t'{26'sd1, 8'd1, 1'b1}});
    // shift 15 is treated as 8
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_FILTER_SHIFT, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CfgIdxUnmapped, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd12345, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_FILTER_SHIFT, 16'd1, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_CALIB_SCANS, 16'hFFFF, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_SCAN, '0, 16'd0, 1'b0, none});
    dir_rows.push_back(dir_row_t'{ROW_CFG, CFG_CALIB_SCANS, 16'd1, 1'b0, none});

    repeat (RstCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_scan(dir_rows[i].data, idle_len(), dir_rows[i].typed, dir_rows[i].want);
      end
    end

    n_items = 0;
    phase = 0;
    while (n_items < RandItems) begin
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 3))
          0: data = '0;
          1: data = 16'd1;
          2: data = '1;
          default: data = CfgDataW'($urandom_range(0, 65535));
        endcase
        write_reg(CFG_CALIB_SCANS, data);
      end
      if ($urandom_range(0, 1) == 1) begin
        data = CfgDataW'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
          0: data[ThrW-1:0] = '0;
          1: data[ThrW-1:0] = '1;
          default: ;
        endcase
        write_reg(CFG_TOUCH_THRESHOLD, data);
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_FILTER_SHIFT, CfgDataW'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CfgIdxUnmapped, CfgDataW'($urandom_range(0, 65535)));
      end

      n = $urandom_range(20, 120);
      center = $urandom_range(0, 300);
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // long output back-pressure while scans keep coming
        hold_req = 1'b1;
        n = 200;
        steady = 1'b1;
      end
      repeat (n) begin
        send_scan(pick_sum(center), steady ? 0 : idle_len(), 1'b0, none);
        n_items++;
      end
      phase++;
    end

    scan_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/tkbf_pkg.sv
design/tkbf_update.sv
design/touch_key_baseline_filter_top.sv
tb/sv/testbench.sv
